### rtl/json_string_escaper_utf8_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the JSON string escaper
// Each macro expects clk and rst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_UTF8_ASSERT_SVH
`define JSON_STRING_ESCAPER_UTF8_ASSERT_SVH

// Same-cycle implication
`define JSE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication
`define JSE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### rtl/jse_pkg.sv
// ---------------------------------------------------------------------------
// jse_pkg
// Shared types and constants of the JSON string escaper.
// ---------------------------------------------------------------------------
package jse_pkg;

    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_U      = 8'h75;
    localparam logic [7:0] CHAR_F      = 8'h66;
    localparam logic [7:0] CHAR_D      = 8'h64;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;

    // Length of the replacement escape text
    localparam logic [2:0] REPL_LEN  = 3'd6;
    localparam logic [2:0] REPL_LAST = REPL_LEN - 3'd1;

    // Code point limits
    localparam logic [20:0] CP_MIN2     = 21'h00080;
    localparam logic [20:0] CP_MIN3     = 21'h00800;
    localparam logic [20:0] CP_SURR_LO  = 21'h0D800;
    localparam logic [20:0] CP_SURR_HI  = 21'h0DFFF;
    localparam logic [20:0] CP_MIN4     = 21'h10000;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;

    // Everything one input byte produces, in output order:
    // opening quote, replacement escapes, core text, closing quote.
    typedef struct packed {
        logic            open;
        logic [2:0]      repl;
        logic [2:0]      core_len;
        logic [5:0][7:0] core;
        logic            close;
    } jse_run_t;

endpackage

### rtl/jse_encode.sv
// ---------------------------------------------------------------------------
// jse_encode
// UTF-8 sequence tracking and escape selection for one byte; produces the
// run descriptor and holds the pending multi-byte sequence.
// ---------------------------------------------------------------------------
`include "json_string_escaper_utf8_assert.svh"

module jse_encode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        in_byte,
    input  logic              first_byte,
    input  logic              last_byte,
    output jse_pkg::jse_run_t run
);
    import jse_pkg::*;

    localparam logic [7:0] CTRL_BS = 8'h08;
    localparam logic [7:0] CTRL_HT = 8'h09;
    localparam logic [7:0] CTRL_LF = 8'h0A;
    localparam logic [7:0] CTRL_FF = 8'h0C;
    localparam logic [7:0] CTRL_CR = 8'h0D;
    localparam logic [7:0] CHAR_B  = 8'h62;
    localparam logic [7:0] CHAR_T  = 8'h74;
    localparam logic [7:0] CHAR_N  = 8'h6E;
    localparam logic [7:0] CHAR_R  = 8'h72;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] d;
        if (n < 4'd10)
        begin
            d = CHAR_ZERO + {4'd0, n};
        end
        else
        begin
            d = 8'h57 + {4'd0, n};
        end
        return d;
    endfunction

    logic [7:0]  held_reg [3];
    logic [1:0]  held_cnt_reg;
    logic [1:0]  held_cnt_next;
    logic [1:0]  need_reg;
    logic [1:0]  need_next;
    logic        held_we;
    logic [1:0]  held_waddr;

    logic [1:0]  held_eff;
    logic [1:0]  need_eff;
    logic        is_cont;
    logic        complete;
    logic [2:0]  seq_len;
    logic [20:0] cp;
    logic        seq_ok;
    logic [2:0]  lead_len;

    // A first mark drops any pending sequence without output
    assign held_eff = first_byte ? 2'd0 : held_cnt_reg;
    assign need_eff = first_byte ? 2'd0 : need_reg;
    assign is_cont  = (in_byte[7:6] == 2'b10);
    assign complete = (need_eff <= 2'd1) || (held_eff == 2'd3);
    assign seq_len  = {1'b0, held_eff} + 3'd1;

    always_comb
    begin
        if (in_byte[7:5] == 3'b110)
        begin
            lead_len = 3'd2;
        end
        else if (in_byte[7:4] == 4'b1110)
        begin
            lead_len = 3'd3;
        end
        else if (in_byte[7:3] == 5'b11110)
        begin
            lead_len = 3'd4;
        end
        else
        begin
            lead_len = 3'd0;
        end
    end

    always_comb
    begin
        case (held_eff)
            2'd1:    cp = {10'd0, held_reg[0][4:0], in_byte[5:0]};
            2'd2:    cp = {5'd0, held_reg[0][3:0], held_reg[1][5:0], in_byte[5:0]};
            default: cp = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0],
                           in_byte[5:0]};
        endcase
        case (held_eff)
            2'd1:    seq_ok = (cp >= CP_MIN2);
            2'd2:    seq_ok = (cp >= CP_MIN3) && !((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
            default: seq_ok = (cp >= CP_MIN4) && (cp <= CP_MAX);
        endcase
    end

    always_comb
    begin
        run           = '0;
        held_cnt_next = held_cnt_reg;
        need_next     = need_reg;
        held_we       = 1'b0;
        held_waddr    = 2'd0;
        run.open      = first_byte;

        if ((held_eff != 2'd0) && is_cont)
        begin
            if (complete)
            begin
                held_cnt_next = 2'd0;
                need_next     = 2'd0;
                if (seq_ok)
                begin
                    run.core_len = seq_len;
                    run.core[0]  = held_reg[0];
                    run.core[1]  = (held_eff == 2'd1) ? in_byte : held_reg[1];
                    run.core[2]  = (held_eff == 2'd2) ? in_byte : held_reg[2];
                    run.core[3]  = in_byte;
                end
                else
                begin
                    run.repl = seq_len;
                end
            end
            else
            begin
                held_we       = 1'b1;
                held_waddr    = held_eff;
                held_cnt_next = held_eff + 2'd1;
                need_next     = need_eff - 2'd1;
            end
        end
        else
        begin
            // Flush whatever was held, then treat the byte on its own
            held_cnt_next = 2'd0;
            need_next     = 2'd0;
            run.repl      = {1'b0, held_eff};
            if ((in_byte == CHAR_QUOTE) || (in_byte == CHAR_BSLASH))
            begin
                run.core_len = 3'd2;
                run.core[0]  = CHAR_BSLASH;
                run.core[1]  = in_byte;
            end
            else if (in_byte[7:5] == 3'b000)
            begin
                run.core[0] = CHAR_BSLASH;
                run.core_len = 3'd2;
                case (in_byte)
                    CTRL_BS: run.core[1] = CHAR_B;
                    CTRL_FF: run.core[1] = CHAR_F;
                    CTRL_LF: run.core[1] = CHAR_N;
                    CTRL_CR: run.core[1] = CHAR_R;
                    CTRL_HT: run.core[1] = CHAR_T;
                    default:
                    begin
                        run.core_len = 3'd6;
                        run.core[1]  = CHAR_U;
                        run.core[2]  = CHAR_ZERO;
                        run.core[3]  = CHAR_ZERO;
                        run.core[4]  = hex_digit(in_byte[7:4]);
                        run.core[5]  = hex_digit(in_byte[3:0]);
                    end
                endcase
            end
            else if (!in_byte[7])
            begin
                run.core_len = 3'd1;
                run.core[0]  = in_byte;
            end
            else if (lead_len >= 3'd2)
            begin
                held_we       = 1'b1;
                held_waddr    = 2'd0;
                held_cnt_next = 2'd1;
                need_next     = lead_len[1:0] - 2'd1;
            end
            else
            begin
                run.repl = run.repl + 3'd1;
            end
        end

        // End of string: flush a cut-off sequence, then close
        if (last_byte)
        begin
            run.repl      = run.repl + {1'b0, held_cnt_next};
            run.close     = 1'b1;
            held_cnt_next = 2'd0;
            need_next     = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= 2'd0;
            need_reg     <= 2'd0;
        end
        else if (take)
        begin
            held_cnt_reg <= held_cnt_next;
            need_reg     <= need_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && held_we)
        begin
            held_reg[held_waddr] <= in_byte;
        end
    end

    `JSE_ASSERT_IMP(a_held_has_need, held_cnt_reg != 2'd0, need_reg != 2'd0)
    `JSE_ASSERT_IMP(a_idle_no_need, held_cnt_reg == 2'd0, need_reg == 2'd0)

endmodule

### rtl/jse_serial.sv
// ---------------------------------------------------------------------------
// jse_serial
// Output serializer: walks one run descriptor and emits it a byte per
// transfer.
// ---------------------------------------------------------------------------
`include "json_string_escaper_utf8_assert.svh"

module jse_serial (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  jse_pkg::jse_run_t run,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              run_end,
    output logic              string_end
);
    import jse_pkg::*;

    typedef enum logic [1:0] {
        PH_OPEN,
        PH_REPL,
        PH_CORE,
        PH_CLOSE
    } phase_t;

    function automatic logic [7:0] repl_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd1:    ch = CHAR_U;
            3'd2:    ch = CHAR_F;
            3'd3:    ch = CHAR_F;
            3'd4:    ch = CHAR_F;
            3'd5:    ch = CHAR_D;
            default: ch = CHAR_BSLASH;
        endcase
        return ch;
    endfunction

    jse_run_t   run_reg;
    phase_t     phase_reg;
    phase_t     start_phase;
    logic       busy_reg;
    logic [2:0] repl_left_reg;
    logic [2:0] sub_reg;
    logic [2:0] core_idx_reg;
    logic       xfer;
    logic       done;

    assign out_valid = busy_reg;
    assign xfer      = busy_reg && !out_stall;
    assign done      = xfer && run_end;
    assign ready     = !busy_reg || done;

    always_comb
    begin
        if (run.open)
        begin
            start_phase = PH_OPEN;
        end
        else if (run.repl != 3'd0)
        begin
            start_phase = PH_REPL;
        end
        else if (run.core_len != 3'd0)
        begin
            start_phase = PH_CORE;
        end
        else
        begin
            start_phase = PH_CLOSE;
        end
    end

    always_comb
    begin
        string_end = 1'b0;
        case (phase_reg)
            PH_OPEN:
            begin
                out_byte = CHAR_QUOTE;
                run_end  = (run_reg.repl == 3'd0) && (run_reg.core_len == 3'd0)
                           && !run_reg.close;
            end
            PH_REPL:
            begin
                out_byte = repl_char(sub_reg);
                run_end  = (sub_reg == REPL_LAST) && (repl_left_reg == 3'd1)
                           && (run_reg.core_len == 3'd0) && !run_reg.close;
            end
            PH_CORE:
            begin
                out_byte = run_reg.core[core_idx_reg];
                run_end  = (core_idx_reg == run_reg.core_len - 3'd1) && !run_reg.close;
            end
            default:
            begin
                out_byte   = CHAR_QUOTE;
                run_end    = 1'b1;
                string_end = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            run_reg       <= '0;
            phase_reg     <= PH_OPEN;
            repl_left_reg <= 3'd0;
            sub_reg       <= 3'd0;
            core_idx_reg  <= 3'd0;
        end
        else if (load)
        begin
            busy_reg      <= 1'b1;
            run_reg       <= run;
            phase_reg     <= start_phase;
            repl_left_reg <= run.repl;
            sub_reg       <= 3'd0;
            core_idx_reg  <= 3'd0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (xfer)
        begin
            // advance to the next byte of the run
            case (phase_reg)
                PH_OPEN:
                begin
                    if (run_reg.repl != 3'd0)
                    begin
                        phase_reg <= PH_REPL;
                    end
                    else if (run_reg.core_len != 3'd0)
                    begin
                        phase_reg <= PH_CORE;
                    end
                    else
                    begin
                        phase_reg <= PH_CLOSE;
                    end
                end
                PH_REPL:
                begin
                    if (sub_reg != REPL_LAST)
                    begin
                        sub_reg <= sub_reg + 3'd1;
                    end
                    else if (repl_left_reg != 3'd1)
                    begin
                        sub_reg       <= 3'd0;
                        repl_left_reg <= repl_left_reg - 3'd1;
                    end
                    else if (run_reg.core_len != 3'd0)
                    begin
                        phase_reg <= PH_CORE;
                    end
                    else
                    begin
                        phase_reg <= PH_CLOSE;
                    end
                end
                PH_CORE:
                begin
                    if (core_idx_reg != run_reg.core_len - 3'd1)
                    begin
                        core_idx_reg <= core_idx_reg + 3'd1;
                    end
                    else
                    begin
                        phase_reg <= PH_CLOSE;
                    end
                end
                default:
                begin
                    phase_reg <= PH_CLOSE;
                end
            endcase
        end
    end

    `JSE_ASSERT_IMP(a_close_ends_run, out_valid && string_end, run_end)
    `JSE_ASSERT_NXT(a_run_continues, out_valid && !out_stall && !run_end, out_valid)

endmodule

### rtl/json_string_escaper_utf8.sv
// ---------------------------------------------------------------------------
// json_string_escaper_utf8
// Quotes and escapes a byte string as JSON text with UTF-8 validation.
// ---------------------------------------------------------------------------
// Input channel: in_valid / in_stall with in_byte, first_byte, last_byte.
// Output channel: out_valid / out_stall with out_byte, run_end, string_end.
// A transfer happens on a rising edge with valid high and stall low.
// An accepted byte sits in the input register, where the escape logic and
// the UTF-8 tracker turn it into a run of 0 to 25 output bytes. The
// serializer loads each run from the input register and emits one byte per
// cycle while out_stall is low, so a byte that yields one result sustains
// one input transfer per cycle; a byte that yields N results holds the input
// until its run is out. Bytes of an unfinished multi-byte sequence yield no
// results of their own.
// run_end marks the last byte of each run; string_end the closing quote.
// While out_stall is high the output byte holds and one more input byte
// can still be taken into the input register; further input then stalls.
// Reset drops any held sequence, the pending input and the current run.
// ---------------------------------------------------------------------------
module json_string_escaper_utf8 (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_end,
    output logic       string_end
);
    import jse_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       first_reg;
    logic       last_reg;
    logic       ser_ready;
    logic       move;
    logic       run_nonempty;
    jse_run_t   run;

    assign move         = in_valid_reg && ser_ready;
    assign in_stall     = in_valid_reg && !move;
    assign run_nonempty = run.open || run.close || (run.repl != 3'd0)
                          || (run.core_len != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (move)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= in_byte;
            first_reg   <= first_byte;
            last_reg    <= last_byte;
        end
    end

    jse_encode u_encode (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (move),
        .in_byte    (in_byte_reg),
        .first_byte (first_reg),
        .last_byte  (last_reg),
        .run        (run)
    );

    // Runs with no output bytes retire without reaching the serializer
    jse_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (move && run_nonempty),
        .run        (run),
        .ready      (ser_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_end    (run_end),
        .string_end (string_end)
    );

endmodule
